[rtl/fcf_pkg.sv]
// Shared types and constants of the feedback comb filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcf_pkg;

  // Store geometry.
  localparam int STORE_DEPTH = 4096;
  localparam int CHANNELS    = 2;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CHW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_AW      = CHW + AW;
  localparam int MEM_DEPTH   = 2 ** MEM_AW;

  // Field widths.
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 12;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = GAIN_W + 1 + SAMPLE_W;
  localparam int FB_W     = PROD_W - 16;
  localparam int SUM_W    = SAMPLE_W + 2;

  // Feedback limit of 0.98 in Q0.16 and the +/-10.0 limits in Q4.19.
  localparam logic [GAIN_W-1:0]       FB_MAX   = 16'd64225;
  localparam logic signed [SUM_W-1:0] CLAMP_HI = 26'sd5242880;
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -26'sd5242880;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_DELAY = 1'b0,
    REG_GAIN  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_length;
    logic [GAIN_W-1:0]  feedback_gain;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/fcf_regs.sv]
// APB-style configuration registers of the feedback comb filter.
// Depends on fcf_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module fcf_regs (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [fcf_pkg::PADDR_W-1:0]  paddr,
  input  wire [fcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output fcf_pkg::cfg_t               cfg_o
);

  fcf_pkg::cfg_t     cfg_q, cfg_d;
  fcf_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = fcf_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fcf_pkg::REG_DELAY: cfg_d.delay_length  = pwdata[fcf_pkg::DELAY_W-1:0];
        fcf_pkg::REG_GAIN:  cfg_d.feedback_gain = pwdata[fcf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fcf_pkg::REG_DELAY: prdata = fcf_pkg::PDATA_W'(cfg_q.delay_length);
      fcf_pkg::REG_GAIN:  prdata = fcf_pkg::PDATA_W'(cfg_q.feedback_gain);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_length  <= fcf_pkg::DELAY_W'(1);
      cfg_q.feedback_gain <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/fcf_pipe.sv]
// Delay-line memory, pointer bookkeeping and multiply-add pipeline of the filter.
// Depends on fcf_pkg for geometry, widths, limits and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module fcf_pipe (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  fcf_pkg::cfg_t                        cfg_i,
  input  wire                                  adv_i,
  input  wire                                  in_valid_i,
  input  wire                                  in_ch_i,
  input  wire signed [fcf_pkg::SAMPLE_W-1:0]   in_sample_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  output logic signed [fcf_pkg::SAMPLE_W-1:0]  out_sample_o
);

  localparam int AW  = fcf_pkg::AW;
  localparam int CHW = fcf_pkg::CHW;
  localparam int SW  = fcf_pkg::SAMPLE_W;

  // Delay-line memory, one ring per channel, addressed {channel, position}.
  logic signed [SW-1:0] mem [fcf_pkg::MEM_DEPTH];

  // Per-channel write pointers and a flag set once a ring has wrapped.
  logic [AW-1:0] wp_q   [fcf_pkg::CHANNELS];
  logic          wrap_q [fcf_pkg::CHANNELS];

  // Accept stage.
  logic [CHW-1:0]              ch;
  logic [AW-1:0]               wp, wp_nxt, rp, dly;
  logic [fcf_pkg::GAIN_W-1:0]  gain;
  logic                        written, hazard, acc;

  // Stage 1: read data back from memory, multiply.
  logic                        s1_valid_q;
  logic [CHW-1:0]              s1_ch_q;
  logic [AW-1:0]               s1_wp_q, s1_rp_q;
  logic signed [SW-1:0]        s1_x_q;
  logic                        s1_written_q;
  logic [fcf_pkg::GAIN_W-1:0]  s1_gain_q;
  logic signed [SW-1:0]        rd_data_q;
  logic                        fwd;
  logic signed [SW-1:0]        d;
  logic signed [fcf_pkg::PROD_W-1:0] prod;

  // Stage 2: add, clamp, write back.
  logic                              s2_valid_q;
  logic [CHW-1:0]                    s2_ch_q;
  logic [AW-1:0]                     s2_wp_q;
  logic signed [SW-1:0]              s2_x_q;
  logic signed [fcf_pkg::FB_W-1:0]   s2_fb_q;
  logic signed [fcf_pkg::SUM_W-1:0]  sum;
  logic signed [SW-1:0]              y;
  logic                              wr_en;

  // Most recent write, forwarded to a read issued at the same edge.
  logic                 lw_valid_q;
  logic [CHW-1:0]       lw_ch_q;
  logic [AW-1:0]        lw_addr_q;
  logic signed [SW-1:0] lw_data_q;

  always_comb begin
    ch = CHW'(32'(in_ch_i) % fcf_pkg::CHANNELS);
    wp = wp_q[ch];
    wp_nxt = (32'(wp) == fcf_pkg::STORE_DEPTH - 1) ? '0 : wp + AW'(1);

    if (cfg_i.delay_length == '0) begin
      dly = AW'(1);
    end else if (32'(cfg_i.delay_length) > fcf_pkg::STORE_DEPTH - 1) begin
      dly = AW'(fcf_pkg::STORE_DEPTH - 1);
    end else begin
      dly = AW'(cfg_i.delay_length);
    end

    gain = (cfg_i.feedback_gain > fcf_pkg::FB_MAX) ? fcf_pkg::FB_MAX : cfg_i.feedback_gain;

    if (wp >= dly) begin
      rp = wp - dly;
    end else begin
      rp = AW'(32'(wp) + fcf_pkg::STORE_DEPTH - 32'(dly));
    end

    // Before the first wrap only the positions below the pointer hold data.
    written = wrap_q[ch] || (dly <= wp);

    // The item in stage 1 has not written yet when this one reads its slot.
    hazard = s1_valid_q && (s1_ch_q == ch) && (s1_wp_q == rp);
  end

  assign in_ready_o = adv_i && !hazard;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    fwd = lw_valid_q && (lw_ch_q == s1_ch_q) && (lw_addr_q == s1_rp_q);
    if (fwd) begin
      d = lw_data_q;
    end else if (s1_written_q) begin
      d = rd_data_q;
    end else begin
      d = '0;
    end
    prod = $signed({1'b0, s1_gain_q}) * d;
  end

  always_comb begin
    sum = fcf_pkg::SUM_W'(s2_x_q) + fcf_pkg::SUM_W'(s2_fb_q);
    if (sum > fcf_pkg::CLAMP_HI) begin
      y = SW'(fcf_pkg::CLAMP_HI);
    end else if (sum < fcf_pkg::CLAMP_LO) begin
      y = SW'(fcf_pkg::CLAMP_LO);
    end else begin
      y = SW'(sum);
    end
  end

  assign wr_en        = adv_i && s2_valid_q;
  assign out_valid_o  = s2_valid_q;
  assign out_sample_o = y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fcf_pkg::CHANNELS; i++) begin
        wp_q[i]   <= '0;
        wrap_q[i] <= 1'b0;
      end
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        wp_q[ch] <= wp_nxt;
        if (wp_nxt == '0) begin
          wrap_q[ch] <= 1'b1;
        end
      end
      if (adv_i) begin
        s1_valid_q <= acc;
        s2_valid_q <= s1_valid_q;
      end
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_data_q    <= mem[{ch, rp}];
      s1_ch_q      <= ch;
      s1_wp_q      <= wp;
      s1_rp_q      <= rp;
      s1_x_q       <= in_sample_i;
      s1_written_q <= written;
      s1_gain_q    <= gain;
    end
    if (adv_i) begin
      s2_ch_q <= s1_ch_q;
      s2_wp_q <= s1_wp_q;
      s2_x_q  <= s1_x_q;
      s2_fb_q <= $signed(prod[fcf_pkg::PROD_W-1:16]);
    end
    if (wr_en) begin
      mem[{s2_ch_q, s2_wp_q}] <= y;
      lw_ch_q   <= s2_ch_q;
      lw_addr_q <= s2_wp_q;
      lw_data_q <= y;
    end
  end

  // The interlock keeps a read from overtaking the write of the item ahead.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s2_valid_q && (s1_ch_q == s2_ch_q) && (s1_rp_q == s2_wp_q)))
    else $error("stage 1 reads a slot that stage 2 has not written yet");

  // A forwarded value always comes from a slot that was written.
  a_fwd_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd) |-> s1_written_q)
    else $error("forwarded from a slot marked as never written");

  // Items move from stage 1 to stage 2 exactly when the pipeline advances.
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (s2_valid_q == $past(s1_valid_q)))
    else $error("stage 2 valid does not follow stage 1");

  // A stalled pipeline holds its stage 2 contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv_i && s2_valid_q) |=> (s2_valid_q && $stable(s2_fb_q) && $stable(s2_x_q)))
    else $error("stage 2 changed while stalled");

endmodule

`default_nettype wire

[rtl/feedback_comb_filter_top.sv]
// Top level of the multichannel feedback comb filter: stream ports, output register.
// Depends on fcf_pkg, fcf_regs and fcf_pipe.
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// Each input word on the s_axis channel carries one signed Q4.19 sample in tdata
// and its channel number in tuser. For every accepted word the block returns
// exactly one filtered sample on the m_axis channel, in order. The result is
// input plus feedback_gain times the result delay_length words back in the same
// channel, shifted right by 16 and clamped to +/-10.0.
// An accepted word passes stage 1, stage 2 and the output register to m_axis.
// Throughput is one word per cycle while the receiver takes every output word.
// The single other exception is a word that follows the word just before it on
// the same channel with an effective delay of one: its memory read waits until
// that word is in stage 2, whose write-back is forwarded to it. The delay lines
// sit in one synchronous memory with one read and one write port; reads that hit
// the slot written at the same edge are forwarded. At reset the write pointers
// go to zero, delay_length to one and feedback_gain to zero. A per-channel wrap
// flag makes never-written slots read as zero, so there is no clearing pass and
// words are taken right after reset. When the receiver stalls, the output register
// holds its word and the whole pipeline freezes; s_axis_tready drops until the
// output word is taken. The user must write configuration over the APB-style port
// only while the block is idle; the block does not enforce it.

module feedback_comb_filter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,   // [23:0] sample_in
  input  wire  [0:0]                   s_axis_tuser,   // [0] channel_index
  // Output stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [23:0]                  m_axis_tdata,   // [23:0] sample_out
  // Configuration port.
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [fcf_pkg::PADDR_W-1:0]  paddr,
  input  wire  [fcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  fcf_pkg::cfg_t cfg;
  logic          adv;
  logic          pipe_valid;
  logic signed [fcf_pkg::SAMPLE_W-1:0] pipe_sample;

  // Output register: it parts the pipeline from the receiver.
  logic                                out_valid_q, out_valid_d;
  logic [fcf_pkg::SAMPLE_W-1:0]        out_data_q;

  fcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The pipeline moves whenever the output register is empty or being drained.
  assign adv = !out_valid_q || m_axis_tready;

  fcf_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .adv_i        (adv),
    .in_valid_i   (s_axis_tvalid),
    .in_ch_i      (s_axis_tuser[0]),
    .in_sample_i  ($signed(s_axis_tdata)),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (pipe_valid),
    .out_sample_o (pipe_sample)
  );

  assign out_valid_d = adv ? pipe_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pipe_valid) begin
      out_data_q <= pipe_sample;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[verif/feedback_comb_filter_top_tb.sv]
// Self-checking testbench for feedback_comb_filter_top: random and directed sample streams,
// an in-bench comb filter predictor and an in-order scoreboard of filtered samples.
// Depends on fcf_pkg and the feedback_comb_filter_top RTL.
`timescale 1ns / 1ps

module feedback_comb_filter_top_tb;

  localparam int unsigned IDLE_LIMIT = 1000;  // cycles without any word moving on either side
  localparam int unsigned HOLD_LEN   = 150;   // long sink stall, in cycles
  localparam int unsigned HOLD_AT    = 400;   // input word count that arms the stall
  localparam int unsigned CALM_LO    = 800;   // no random idling for words in
  localparam int unsigned CALM_HI    = 1100;  // [CALM_LO, CALM_HI)

  // One input word: channel and signed Q4.19 sample.
  typedef struct packed {
    logic                                ch;
    logic signed [fcf_pkg::SAMPLE_W-1:0] smp;
  } samp_word_t;

  // DUT connections. Every input starts at a known value.
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata  = '0;  // [23:0] sample_in
  logic [0:0]                    s_axis_tuser  = '0;  // [0] channel_index
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;        // [23:0] sample_out
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [fcf_pkg::PADDR_W-1:0]   paddr         = '0;
  logic [fcf_pkg::PDATA_W-1:0]   pwdata        = '0;
  logic [fcf_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  feedback_comb_filter_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: a shadow of the delay lines, write pointers and registers.
  bit signed [fcf_pkg::SAMPLE_W-1:0] echo_mem [fcf_pkg::CHANNELS][fcf_pkg::STORE_DEPTH];
  int unsigned                       wr_ptr   [fcf_pkg::CHANNELS];
  logic [fcf_pkg::DELAY_W-1:0]       cfg_delay = 12'd1;
  logic [fcf_pkg::GAIN_W-1:0]        cfg_gain  = '0;

  // Words waiting to be offered, and filtered samples waiting to come out.
  samp_word_t                          pending_q [$];
  logic signed [fcf_pkg::SAMPLE_W-1:0] filtered_q [$];

  int unsigned queued_total = 0;  // words pushed into pending_q so far
  int unsigned in_count     = 0;  // words accepted by the DUT so far
  int unsigned err_cnt      = 0;
  bit          in_taken     = 1'b0;

  // The sender and the sink both stop idling while in_count sits in this window.
  wire calm = (in_count >= CALM_LO) && (in_count < CALM_HI);

  // Runs one sample through the comb filter and returns the filtered sample.
  // The delay is held within 1..STORE_DEPTH-1 and the gain at 0.98 at most;
  // the sum saturates at +/-10.0 before it goes back into the delay line.
  function automatic logic signed [fcf_pkg::SAMPLE_W-1:0] comb_step(
    input logic ch_in, input logic signed [fcf_pkg::SAMPLE_W-1:0] x);
    int unsigned ch, dly, gain, rd;
    longint      prod, acc;
    ch   = int'(ch_in) % fcf_pkg::CHANNELS;
    dly  = cfg_delay;
    gain = cfg_gain;
    if (dly < 1) dly = 1;
    if (dly > fcf_pkg::STORE_DEPTH - 1) dly = fcf_pkg::STORE_DEPTH - 1;
    if (gain > int'(fcf_pkg::FB_MAX)) gain = int'(fcf_pkg::FB_MAX);
    rd   = (wr_ptr[ch] + fcf_pkg::STORE_DEPTH - dly) % fcf_pkg::STORE_DEPTH;
    prod = longint'(gain) * longint'(echo_mem[ch][rd]);
    acc  = longint'(x) + (prod >>> 16);
    if (acc > longint'(fcf_pkg::CLAMP_HI)) acc = longint'(fcf_pkg::CLAMP_HI);
    if (acc < longint'(fcf_pkg::CLAMP_LO)) acc = longint'(fcf_pkg::CLAMP_LO);
    echo_mem[ch][wr_ptr[ch]] = acc[fcf_pkg::SAMPLE_W-1:0];
    wr_ptr[ch] = (wr_ptr[ch] + 1) % fcf_pkg::STORE_DEPTH;
    return acc[fcf_pkg::SAMPLE_W-1:0];
  endfunction

  // Scoreboard. Runs at the rising edge, where inputs are stable and the DUT
  // outputs still show their pre-edge values. A word accepted on the input side
  // is filtered right away; a word accepted on the output side is checked
  // against the oldest filtered sample.
  always @(posedge clk_i) begin : scoreboard
    logic signed [fcf_pkg::SAMPLE_W-1:0] want;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) begin
      filtered_q.push_back(comb_step(s_axis_tuser[0], s_axis_tdata));
      in_count++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: sample_out with nothing expected: expected none, actual %0d",
                 $time, $signed(m_axis_tdata));
        err_cnt++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want, $signed(m_axis_tdata));
          err_cnt++;
        end
      end
    end
  end

  // Sender. Changes its outputs at the falling edge only. A new word goes out
  // when the line is free or the current word was taken at the last edge; with a
  // chance of about one in seven it idles instead, except inside the calm window.
  always @(negedge clk_i) begin : feed_driver
    samp_word_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        nxt = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.smp;
        s_axis_tuser  <= nxt.ch;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink. Idles at random like the sender, and once holds off for a long
  // stretch while the sender keeps offering, so that the pipeline fills and
  // s_axis_tready has to drop.
  bit          hold_armed = 1'b0;
  int unsigned hold_left  = 0;

  always @(negedge clk_i) begin : sink_driver
    if (rst_ni) begin
      if (!hold_armed && in_count >= HOLD_AT) begin
        hold_armed = 1'b1;
        hold_left  = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Register write over the APB-style port: setup cycle, then access cycle.
  // The shadow register follows once the write has gone through.
  task automatic reg_write(input fcf_pkg::reg_idx_e idx,
                           input logic [fcf_pkg::PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fcf_pkg::PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fcf_pkg::REG_DELAY: cfg_delay = val[fcf_pkg::DELAY_W-1:0];
      fcf_pkg::REG_GAIN:  cfg_gain  = val[fcf_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_sample(input logic ch,
                              input logic signed [fcf_pkg::SAMPLE_W-1:0] smp);
    pending_q.push_back('{ch: ch, smp: smp});
    queued_total++;
  endtask

  // Waits until every queued word was accepted and every filtered sample came
  // out, then lets the pipeline settle before anything else.
  task automatic wait_drained();
    while (in_count != queued_total || filtered_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random sample: mostly full range, with extremes, values around the
  // +/-10.0 clamp and small values mixed in.
  function automatic logic signed [fcf_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
      1, 2:    return ($urandom_range(1) ? 24'sd5242880 : -24'sd5242880)
                      + fcf_pkg::SAMPLE_W'($urandom_range(128) - 64);
      3, 4:    return fcf_pkg::SAMPLE_W'(int'($urandom_range(4095)) - 2048);
      default: return fcf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // One phase: wait for idle, set both registers, then stream n random words.
  // Channels come in short runs so that back-to-back words on one channel
  // (the read-after-write case at a delay of one) occur often.
  task automatic run_phase(input logic [fcf_pkg::DELAY_W-1:0] dly,
                           input logic [fcf_pkg::GAIN_W-1:0] gain,
                           input int n_words);
    logic ch;
    wait_drained();
    reg_write(fcf_pkg::REG_DELAY, fcf_pkg::PDATA_W'(dly));
    reg_write(fcf_pkg::REG_GAIN, fcf_pkg::PDATA_W'(gain));
    ch = 1'($urandom);
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(99) >= 60) ch = ~ch;
      queue_sample(ch, rand_sample());
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (delay one, no feedback): field extremes, values right at
    // and just past the clamp, and both channels.
    queue_sample(1'b0, 24'sh7FFFFF);
    queue_sample(1'b1, 24'sh800000);
    queue_sample(1'b0, 24'sd5242880);
    queue_sample(1'b1, -24'sd5242880);
    queue_sample(1'b0, 24'sd5242881);
    queue_sample(1'b1, -24'sd5242881);
    queue_sample(1'b0, 24'sd0);
    queue_sample(1'b0, -24'sd1);
    queue_sample(1'b1, 24'sd1);
    queue_sample(1'b1, 24'sh555555);
    wait_drained();

    // A delay of zero acts as one and a gain above 0.98 acts as 0.98. Repeated
    // large samples on each channel make the feedback run away into the clamp;
    // the sign change afterwards pulls it back out.
    reg_write(fcf_pkg::REG_DELAY, fcf_pkg::PDATA_W'(0));
    reg_write(fcf_pkg::REG_GAIN, fcf_pkg::PDATA_W'(16'hFFFF));
    repeat (4) queue_sample(1'b0, 24'sd4000000);
    repeat (4) queue_sample(1'b1, -24'sd4000000);
    queue_sample(1'b0, 24'sh800000);
    queue_sample(1'b1, 24'sh7FFFFF);
    queue_sample(1'b0, -24'sd1);
    queue_sample(1'b1, 24'sd1);

    // Random part over several settings, the extremes among them.
    run_phase(12'd1,    fcf_pkg::FB_MAX, 215);
    run_phase(12'd4095, fcf_pkg::FB_MAX, 215);
    run_phase(12'd2,    16'd32768, 215);
    run_phase(fcf_pkg::DELAY_W'($urandom_range(1, 64)), fcf_pkg::GAIN_W'($urandom), 215);
    run_phase(12'd0,    16'd0,    215);
    run_phase(fcf_pkg::DELAY_W'($urandom), fcf_pkg::GAIN_W'($urandom), 215);
    run_phase(12'd5,    16'hFFFF, 215);
    run_phase(12'd3,    16'd1,    215);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0 && filtered_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fcf_pkg.sv
rtl/fcf_regs.sv
rtl/fcf_pipe.sv
rtl/feedback_comb_filter_top.sv
verif/feedback_comb_filter_top_tb.sv
